// ===== src/thsf_pkg.sv =====
// Package for the two-hit segment fit: field widths, transaction structs,
// divider lane records and the saturation bounds of each result kind.
// No dependencies.
package thsf_pkg;

    localparam int unsigned COORD_W = 24;            // z and coordinate width
    localparam int unsigned VAR_W   = 32;            // variance width
    localparam int unsigned Q_W     = 48;            // quotient bits, one per divider cell
    localparam int unsigned DEN_W   = 49;            // divisor width (dz squared)
    localparam int unsigned NUM_W   = DEN_W + Q_W - 23; // 74-bit dividend
    localparam int unsigned LANES   = 8;             // four divisions per plane

    // Lane position inside one plane.
    localparam int unsigned L_SLOPE  = 0;
    localparam int unsigned L_IMPACT = 1;
    localparam int unsigned L_SVAR   = 2;
    localparam int unsigned L_COV    = 3;

    typedef enum logic [1:0] {
        K_SLOPE  = 2'd0,
        K_IMPACT = 2'd1,
        K_SVAR   = 2'd2,
        K_COV    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [COORD_W-1:0] first_z;
        logic [COORD_W-1:0] first_bend_coord;
        logic [COORD_W-1:0] first_nonbend_coord;
        logic [VAR_W-1:0]   first_bend_var;
        logic [VAR_W-1:0]   first_nonbend_var;
        logic [COORD_W-1:0] second_z;
        logic [COORD_W-1:0] second_bend_coord;
        logic [COORD_W-1:0] second_nonbend_coord;
        logic [VAR_W-1:0]   second_bend_var;
        logic [VAR_W-1:0]   second_nonbend_var;
    } t_in_item;

    typedef struct packed {
        logic [31:0] bend_slope;
        logic [23:0] bend_impact;
        logic [47:0] bend_slope_var;
        logic [39:0] bend_cross_cov;
        logic [31:0] nonbend_slope;
        logic [23:0] nonbend_impact;
        logic [47:0] nonbend_slope_var;
        logic [39:0] nonbend_cross_cov;
        logic        zero_gap;
    } t_out_item;

    // Magnitude division request: n / d, result sign and kind.
    typedef struct packed {
        logic [NUM_W-1:0] n;
        logic [DEN_W-1:0] d;
        logic             neg;
        t_kind            kind;
    } t_num_lane;

    // State of one division as it walks down the cell chain. The low
    // dividend bits shift out of the top of nq while quotient bits shift in.
    typedef struct packed {
        logic [DEN_W-1:0] r;
        logic [Q_W-1:0]   nq;
        logic [DEN_W-1:0] d;
        logic             neg;
        logic             sat;
        t_kind            kind;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [LANES-1:0] lane;
        logic                  zero_gap;
    } t_div_row;

    // Largest positive magnitude of each result field.
    function automatic logic [DEN_W-1:0] bound_pos(input t_kind kind);
        logic [DEN_W-1:0] b;
        unique case (kind)
            K_SLOPE:  b = DEN_W'((64'd1 << 31) - 64'd1);
            K_IMPACT: b = DEN_W'((64'd1 << 23) - 64'd1);
            K_SVAR:   b = DEN_W'((64'd1 << 48) - 64'd1);
            K_COV:    b = DEN_W'((64'd1 << 39) - 64'd1);
            default:  b = '0;
        endcase
        return b;
    endfunction

    // Largest negative magnitude of each result field.
    function automatic logic [DEN_W-1:0] bound_neg(input t_kind kind);
        logic [DEN_W-1:0] b;
        unique case (kind)
            K_SLOPE:  b = DEN_W'(64'd1 << 31);
            K_IMPACT: b = DEN_W'(64'd1 << 23);
            K_SVAR:   b = '0;
            K_COV:    b = DEN_W'(64'd1 << 39);
            default:  b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/thsf_prep.sv =====
// Front end of the segment fit: gap, products and sums, then the eight
// division requests, then the divider start values. Three register stages.
// Depends on thsf_pkg.
module thsf_prep import thsf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_div_row o_row
);

    // Stage 1 registers.
    logic                      r1_valid;
    logic [COORD_W:0]          r1_absdz, n1_absdz;
    logic                      r1_dzneg, n1_dzneg;
    logic                      r1_zg, n1_zg;
    logic signed [2*COORD_W-1:0] r1_prod [4];
    logic signed [2*COORD_W-1:0] n1_prod [4];
    logic signed [COORD_W:0]   r1_diff [2];
    logic signed [COORD_W:0]   n1_diff [2];
    logic [VAR_W:0]            r1_vsum [2];
    logic [VAR_W:0]            n1_vsum [2];
    logic [VAR_W-1:0]          r1_v1 [2];

    // Stage 2 registers.
    logic                      r2_valid;
    t_num_lane [LANES-1:0]     r2_lane, n2_lane;
    logic                      r2_zg;

    // Stage 3 registers.
    logic                      r3_valid;
    t_div_row                  r3_row, n3_row;

    logic signed [COORD_W:0]   w_dz;
    logic [DEN_W-1:0]          w_dz2;
    logic signed [2*COORD_W:0] w_imp [2];
    logic [2*COORD_W:0]        w_imp_mag [2];
    logic [COORD_W:0]          w_diff_mag [2];

    always_comb begin
        w_dz = $signed({i_item.first_z[COORD_W-1], i_item.first_z})
             - $signed({i_item.second_z[COORD_W-1], i_item.second_z});
        n1_dzneg = w_dz[COORD_W];
        n1_absdz = w_dz[COORD_W] ? (COORD_W+1)'(-w_dz) : w_dz;
        n1_zg    = (i_item.first_z == i_item.second_z);
        // Impact numerator is z1*c2 - z2*c1.
        n1_prod[0] = $signed(i_item.first_z) * $signed(i_item.second_bend_coord);
        n1_prod[1] = $signed(i_item.second_z) * $signed(i_item.first_bend_coord);
        n1_prod[2] = $signed(i_item.first_z) * $signed(i_item.second_nonbend_coord);
        n1_prod[3] = $signed(i_item.second_z) * $signed(i_item.first_nonbend_coord);
        n1_diff[0] = $signed({i_item.first_bend_coord[COORD_W-1], i_item.first_bend_coord})
                   - $signed({i_item.second_bend_coord[COORD_W-1],
                              i_item.second_bend_coord});
        n1_diff[1] = $signed({i_item.first_nonbend_coord[COORD_W-1],
                              i_item.first_nonbend_coord})
                   - $signed({i_item.second_nonbend_coord[COORD_W-1],
                              i_item.second_nonbend_coord});
        n1_vsum[0] = {1'b0, i_item.first_bend_var} + {1'b0, i_item.second_bend_var};
        n1_vsum[1] = {1'b0, i_item.first_nonbend_var} + {1'b0, i_item.second_nonbend_var};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_absdz <= n1_absdz;
            r1_dzneg <= n1_dzneg;
            r1_zg    <= n1_zg;
            r1_prod  <= n1_prod;
            r1_diff  <= n1_diff;
            r1_vsum  <= n1_vsum;
            r1_v1[0] <= i_item.first_bend_var;
            r1_v1[1] <= i_item.first_nonbend_var;
            r2_lane  <= n2_lane;
            r2_zg    <= r1_zg;
            r3_row   <= n3_row;
        end
    end

    always_comb begin
        w_dz2 = DEN_W'(r1_absdz * r1_absdz);
        for (int p = 0; p < 2; p++) begin
            w_imp[p] = $signed({r1_prod[2*p][2*COORD_W-1], r1_prod[2*p]})
                     - $signed({r1_prod[2*p+1][2*COORD_W-1], r1_prod[2*p+1]});
            w_imp_mag[p]  = w_imp[p][2*COORD_W] ? (2*COORD_W+1)'(-w_imp[p]) : w_imp[p];
            w_diff_mag[p] = r1_diff[p][COORD_W] ? (COORD_W+1)'(-r1_diff[p]) : r1_diff[p];

            n2_lane[4*p+L_SLOPE].n    = NUM_W'({w_diff_mag[p], 20'd0});
            n2_lane[4*p+L_SLOPE].d    = DEN_W'(r1_absdz);
            n2_lane[4*p+L_SLOPE].neg  = r1_diff[p][COORD_W] ^ r1_dzneg;
            n2_lane[4*p+L_SLOPE].kind = K_SLOPE;

            n2_lane[4*p+L_IMPACT].n    = NUM_W'(w_imp_mag[p]);
            n2_lane[4*p+L_IMPACT].d    = DEN_W'(r1_absdz);
            n2_lane[4*p+L_IMPACT].neg  = w_imp[p][2*COORD_W] ^ r1_dzneg;
            n2_lane[4*p+L_IMPACT].kind = K_IMPACT;

            n2_lane[4*p+L_SVAR].n    = NUM_W'({r1_vsum[p], 40'd0});
            n2_lane[4*p+L_SVAR].d    = w_dz2;
            n2_lane[4*p+L_SVAR].neg  = 1'b0;
            n2_lane[4*p+L_SVAR].kind = K_SVAR;

            n2_lane[4*p+L_COV].n    = NUM_W'({r1_v1[p], 20'd0});
            n2_lane[4*p+L_COV].d    = DEN_W'(r1_absdz);
            n2_lane[4*p+L_COV].neg  = r1_dzneg;
            n2_lane[4*p+L_COV].kind = K_COV;
        end
    end

    // A quotient that needs more than Q_W bits is beyond every field bound.
    always_comb begin
        n3_row.zero_gap = r2_zg;
        for (int l = 0; l < LANES; l++) begin
            n3_row.lane[l].r    = DEN_W'(r2_lane[l].n[NUM_W-1:Q_W]);
            n3_row.lane[l].nq   = r2_lane[l].n[Q_W-1:0];
            n3_row.lane[l].d    = r2_lane[l].d;
            n3_row.lane[l].neg  = r2_lane[l].neg;
            n3_row.lane[l].sat  = (DEN_W'(r2_lane[l].n[NUM_W-1:Q_W]) >= r2_lane[l].d);
            n3_row.lane[l].kind = r2_lane[l].kind;
        end
    end

    assign o_valid = r3_valid;
    assign o_row   = r3_row;

endmodule

// ===== src/thsf_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit for all eight
// lanes, then the row moves on to the next cell.
// Depends on thsf_pkg.
module thsf_div_cell import thsf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_row i_row,
    output logic     o_valid,
    output t_div_row o_row
);

    logic     r_valid;
    t_div_row r_row, n_row;
    logic [DEN_W:0] w_tmp [LANES];
    logic [DEN_W:0] w_sub [LANES];
    logic           w_ge  [LANES];

    always_comb begin
        n_row = i_row;
        for (int l = 0; l < LANES; l++) begin
            w_tmp[l] = {i_row.lane[l].r, i_row.lane[l].nq[Q_W-1]};
            w_sub[l] = w_tmp[l] - {1'b0, i_row.lane[l].d};
            w_ge[l]  = (w_tmp[l] >= {1'b0, i_row.lane[l].d});
            n_row.lane[l].r  = w_ge[l] ? w_sub[l][DEN_W-1:0] : w_tmp[l][DEN_W-1:0];
            n_row.lane[l].nq = {i_row.lane[l].nq[Q_W-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;

endmodule

// ===== src/thsf_round.sv =====
// Rounding and saturation of the finished quotients into the result fields.
// Pure logic; depends on thsf_pkg.
module thsf_round import thsf_pkg::*; (
    input  t_div_row  i_row,
    output t_out_item o_item
);

    logic [DEN_W-1:0] w_val [LANES];
    logic [DEN_W-1:0] w_qr  [LANES];
    logic [DEN_W-1:0] w_bp  [LANES];
    logic [DEN_W-1:0] w_bn  [LANES];
    logic             w_up  [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            // Ties round away from zero: bump when twice the remainder reaches d.
            w_up[l] = ({i_row.lane[l].r, 1'b0} >= {1'b0, i_row.lane[l].d});
            w_qr[l] = {1'b0, i_row.lane[l].nq} + DEN_W'(w_up[l]);
            w_bp[l] = bound_pos(i_row.lane[l].kind);
            w_bn[l] = bound_neg(i_row.lane[l].kind);
            if (i_row.lane[l].neg) begin
                w_val[l] = (i_row.lane[l].sat || w_qr[l] > w_bn[l]) ? -w_bn[l] : -w_qr[l];
            end else begin
                w_val[l] = (i_row.lane[l].sat || w_qr[l] > w_bp[l]) ? w_bp[l] : w_qr[l];
            end
        end

        if (i_row.zero_gap) begin
            o_item          = '0;
            o_item.zero_gap = 1'b1;
        end else begin
            o_item.bend_slope        = w_val[L_SLOPE][31:0];
            o_item.bend_impact       = w_val[L_IMPACT][23:0];
            o_item.bend_slope_var    = w_val[L_SVAR][47:0];
            o_item.bend_cross_cov    = w_val[L_COV][39:0];
            o_item.nonbend_slope     = w_val[4+L_SLOPE][31:0];
            o_item.nonbend_impact    = w_val[4+L_IMPACT][23:0];
            o_item.nonbend_slope_var = w_val[4+L_SVAR][47:0];
            o_item.nonbend_cross_cov = w_val[4+L_COV][39:0];
            o_item.zero_gap          = 1'b0;
        end
    end

endmodule

// ===== src/two_hit_segment_fit.sv =====
// Top of the two-hit segment fit: front end, divider cell chain, rounding and the
// output register. Depends on thsf_pkg, thsf_prep, thsf_div_cell and thsf_round.
//
// Usage: each input transaction on i_in_valid / i_in_data carries one pair
// of hits; each output transaction on o_out_valid / o_out_data carries the
// slope, impact, slope variance and cross covariance of both planes.
// A pair is taken when i_in_valid is high and o_in_stall is low; a result
// leaves when o_out_valid is high and i_out_stall is low.
//
// The path runs through three front-end stages, 48 divider cells and the
// output register. Throughput is one transaction per cycle while the output
// does not hold the chain; every cell produces one quotient bit of all
// eight divisions and passes the row to its neighbor.
//
// Reset clears every valid bit, so the pipeline comes up empty. When the
// receiver stalls, the result stays in the output register and the chain
// keeps moving as long as its last cell is empty; once a finished result
// sits there too, the whole chain holds and o_in_stall goes high.
module two_hit_segment_fit import thsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      w_vld [Q_W+1];
    t_div_row  w_row [Q_W+1];
    logic      w_out_load;
    logic      w_adv;
    t_out_item w_result;
    logic      r_out_valid;
    t_out_item r_out_data;

    // The output register takes a new result when it is empty or draining.
    // The chain advances when that happens or when its last cell holds nothing.
    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_adv      = w_out_load || !w_vld[Q_W];
    assign o_in_stall = !w_adv;

    thsf_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_valid (w_vld[0]),
        .o_row   (w_row[0])
    );

    // One cell per quotient bit, most significant first.
    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        thsf_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_vld[g]),
            .i_row   (w_row[g]),
            .o_valid (w_vld[g+1]),
            .o_row   (w_row[g+1])
        );
    end

    thsf_round u_round (
        .i_row  (w_row[Q_W]),
        .o_item (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/thsf_checker.sv =====
// Port-level checker for the two-hit segment fit and its bind statement.
// Depends on thsf_pkg and the two_hit_segment_fit ports.
module thsf_checker import thsf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");

    // The block only pushes back when a result waits at a stalled output.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    // A zero gap result carries nothing but the flag.
    a_zero_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_gap |->
            o_out_data.bend_slope == 0 && o_out_data.bend_impact == 0 &&
            o_out_data.bend_slope_var == 0 && o_out_data.bend_cross_cov == 0 &&
            o_out_data.nonbend_slope == 0 && o_out_data.nonbend_impact == 0 &&
            o_out_data.nonbend_slope_var == 0 && o_out_data.nonbend_cross_cov == 0)
        else $error("zero gap result with nonzero fields");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind two_hit_segment_fit thsf_checker u_thsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

// ===== bench/two_hit_segment_fit_tb.sv =====
// Self-checking bench for two_hit_segment_fit: directed and random hit pairs,
// a bit-exact line-fit predictor, and randomized sender bursts and receiver stalls.
// Depends on thsf_pkg and the two_hit_segment_fit RTL.
module two_hit_segment_fit_tb;
    import thsf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    // Predicted fits wait here in transaction order until the block delivers them.
    t_out_item   fits_pending[$];
    int unsigned err_count;
    int unsigned quiet_cycles;

    two_hit_segment_fit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Rounded quotient, ties away from zero, clamped to [lo, hi]. All operands
    // are held at 128 bits, so the exact products never overflow.
    function automatic logic signed [127:0] round_div_clamp(
        input logic signed [127:0] num,
        input logic signed [127:0] den,
        input logic signed [127:0] lo,
        input logic signed [127:0] hi
    );
        logic signed [127:0] n_mag;
        logic signed [127:0] d_mag;
        logic signed [127:0] q;
        n_mag = (num < 0) ? -num : num;
        d_mag = (den < 0) ? -den : den;
        q = (2 * n_mag + d_mag) / (2 * d_mag);
        if ((num < 0) != (den < 0))
            q = -q;
        if (q < lo)
            q = lo;
        if (q > hi)
            q = hi;
        return q;
    endfunction

    // One plane of the fit: slope, impact at z = 0, slope variance and the
    // coordinate-slope covariance, each in its output format.
    function automatic void fit_plane(
        input  logic signed [127:0] z1,
        input  logic signed [127:0] z2,
        input  logic signed [127:0] c1,
        input  logic signed [127:0] c2,
        input  logic signed [127:0] v1,
        input  logic signed [127:0] v2,
        output logic [31:0] slope,
        output logic [23:0] impact,
        output logic [47:0] slope_var,
        output logic [39:0] cross_cov
    );
        logic signed [127:0] dz;
        logic signed [127:0] r;
        dz = z1 - z2;
        r = round_div_clamp((c1 - c2) <<< 20, dz, -(128'sd1 <<< 31), (128'sd1 <<< 31) - 1);
        slope = r[31:0];
        r = round_div_clamp(z1 * c2 - z2 * c1, dz, -(128'sd1 <<< 23), (128'sd1 <<< 23) - 1);
        impact = r[23:0];
        r = round_div_clamp((v1 + v2) <<< 40, dz * dz, 128'sd0, (128'sd1 <<< 48) - 1);
        slope_var = r[47:0];
        r = round_div_clamp(v1 <<< 20, dz, -(128'sd1 <<< 39), (128'sd1 <<< 39) - 1);
        cross_cov = r[39:0];
    endfunction

    function automatic t_out_item predict_fit(input t_in_item x);
        t_out_item f;
        logic signed [127:0] z1;
        logic signed [127:0] z2;
        f  = '0;
        z1 = $signed(x.first_z);
        z2 = $signed(x.second_z);
        if (z1 == z2) begin
            // Hits on the same z plane: no line, only the flag is set.
            f.zero_gap = 1'b1;
        end else begin
            fit_plane(z1, z2, $signed(x.first_bend_coord), $signed(x.second_bend_coord),
                      {96'd0, x.first_bend_var}, {96'd0, x.second_bend_var},
                      f.bend_slope, f.bend_impact, f.bend_slope_var, f.bend_cross_cov);
            fit_plane(z1, z2, $signed(x.first_nonbend_coord),
                      $signed(x.second_nonbend_coord),
                      {96'd0, x.first_nonbend_var}, {96'd0, x.second_nonbend_var},
                      f.nonbend_slope, f.nonbend_impact, f.nonbend_slope_var,
                      f.nonbend_cross_cov);
        end
        return f;
    endfunction

    // Drive one hit pair at the falling edge and hold it until it is accepted.
    // The prediction is queued at the accepting edge.
    task automatic send_pair(input t_in_item x);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        do
            @(posedge i_clk);
        while (o_in_stall);
        fits_pending.push_back(predict_fit(x));
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Random hit pair. Nearly half the pairs are fully random; some have a small z gap
    // so the results saturate, some share z, some sit on the field limits, some are modest.
    function automatic t_in_item rand_pair();
        t_in_item x;
        int unsigned mode;
        x = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom});
        mode = $urandom_range(99);
        if (mode < 20) begin
            x.second_z = x.first_z + 24'($signed($urandom_range(64)) - 32);
        end else if (mode < 30) begin
            x.second_z = x.first_z;
        end else if (mode < 40) begin
            x.first_z  = $urandom_range(1) ? 24'h7fffff : 24'h800000;
            x.second_z = $urandom_range(1) ? 24'h7fffff : 24'h800000;
            x.first_bend_coord     = $urandom_range(1) ? 24'h7fffff : 24'h800000;
            x.second_nonbend_coord = $urandom_range(1) ? 24'h7fffff : 24'h800000;
            x.first_bend_var       = $urandom_range(1) ? 32'hffffffff : 32'h0;
            x.second_nonbend_var   = $urandom_range(1) ? 32'hffffffff : 32'h0;
        end else if (mode < 55) begin
            // Modest coordinates and gaps keep most results inside their fields.
            x.first_z  = 24'($signed($urandom_range(200000)) - 100000);
            x.second_z = 24'($signed($urandom_range(200000)) - 100000);
            x.first_bend_coord     = 24'($signed($urandom_range(20000)) - 10000);
            x.second_bend_coord    = 24'($signed($urandom_range(20000)) - 10000);
            x.first_nonbend_coord  = 24'($signed($urandom_range(20000)) - 10000);
            x.second_nonbend_coord = 24'($signed($urandom_range(20000)) - 10000);
        end
        return x;
    endfunction

    function automatic t_in_item make_pair(
        input logic [23:0] z1, input logic [23:0] c1, input logic [31:0] v1,
        input logic [23:0] z2, input logic [23:0] c2, input logic [31:0] v2
    );
        t_in_item x;
        x.first_z              = z1;
        x.first_bend_coord     = c1;
        x.first_nonbend_coord  = -c1;
        x.first_bend_var       = v1;
        x.first_nonbend_var    = ~v1;
        x.second_z             = z2;
        x.second_bend_coord    = c2;
        x.second_nonbend_coord = -c2;
        x.second_bend_var      = v2;
        x.second_nonbend_var   = ~v2;
        return x;
    endfunction

    // Shared z: the flag must be set and every other field must be zero,
    // whatever the coordinates and variances hold.
    task automatic test_zero_gap();
        send_pair(make_pair(24'h0, 24'h7fffff, 32'hffffffff, 24'h0, 24'h800000, 32'h1));
        send_pair(make_pair(24'h7fffff, 24'h123456, 32'h0, 24'h7fffff, 24'h654321, 32'h0));
        send_pair(make_pair(24'h800000, 24'h800000, 32'h5555aaaa, 24'h800000, 24'h7fffff,
                            32'haaaa5555));
    endtask

    // Largest and smallest gaps with coordinates and variances at their limits.
    task automatic test_field_extremes();
        send_pair(make_pair(24'h7fffff, 24'h7fffff, 32'hffffffff,
                            24'h800000, 24'h800000, 32'hffffffff));
        send_pair(make_pair(24'h800000, 24'h7fffff, 32'h0, 24'h7fffff, 24'h800000, 32'h0));
        send_pair(make_pair(24'h000001, 24'h7fffff, 32'hffffffff,
                            24'h000000, 24'h800000, 32'hffffffff));
        send_pair(make_pair(24'h000000, 24'h800000, 32'hffffffff,
                            24'h000001, 24'h7fffff, 32'h0));
        send_pair(make_pair(24'h7fffff, 24'h0, 32'h0, 24'h7ffffe, 24'h0, 32'h0));
    endtask

    // Unit gaps in both orders drive every result past its bound; the last pair has a wider gap.
    task automatic test_saturation();
        send_pair(make_pair(24'h000101, 24'h400000, 32'h80000000,
                            24'h000100, 24'hc00000, 32'h80000000));
        send_pair(make_pair(24'h000100, 24'h400000, 32'h80000000,
                            24'h000101, 24'hc00000, 32'h80000000));
        send_pair(make_pair(24'h000400, 24'h000010, 32'h00001000,
                            24'h000000, 24'h000008, 32'h00002000));
    endtask

    // Even gaps against odd numerators can land exactly on half of the last unit,
    // so the ties must go away from zero (upward for the slope variance).
    task automatic test_rounding_ties();
        send_pair(make_pair(24'h000002, 24'h000001, 32'h1, 24'h000000, 24'h000000, 32'h0));
        send_pair(make_pair(24'h000000, 24'h000001, 32'h1, 24'h000002, 24'h000000, 32'h0));
        send_pair(make_pair(24'h000003, 24'hffffff, 32'h3, 24'h000001, 24'h000002, 32'h1));
        send_pair(make_pair(24'hfffffd, 24'h000005, 32'h7, 24'h000003, 24'hfffffb, 32'h9));
        send_pair(make_pair(24'h100000, 24'h000003, 32'h3, 24'h000000, 24'h000000, 32'h0));
        send_pair(make_pair(24'h001000, 24'h000801, 32'h11, 24'hfff000, 24'hfff7ff, 32'h22));
        pause_sender(1);
    endtask

    // Random pairs in bursts of random length with random gaps between most of them.
    task automatic test_random_pairs();
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(24, 1);
            repeat (burst) send_pair(rand_pair());
            sent += burst;
            if ($urandom_range(3) != 0)
                pause_sender($urandom_range(8, 1));
        end
        pause_sender(1);
    endtask

    // The receiver stalls on its own schedule: stretches with no stall,
    // stretches of random stall, and a regular on/off pattern.
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned step;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(2);
            span = $urandom_range(120, 10);
            for (step = 0; step < span; step++) begin
                @(negedge i_clk);
                unique case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(3) == 0);
                    default: i_out_stall <= (step % 5) < 2;
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            err_count++;
        end
    endtask

    // Every delivered result is compared with the oldest pending prediction.
    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (fits_pending.size() == 0) begin
                    $display("%0t: result with no pending transaction, actual %h",
                             $realtime, o_out_data);
                    err_count++;
                end else begin
                    want = fits_pending.pop_front();
                    check_field("bend_slope", want.bend_slope, o_out_data.bend_slope);
                    check_field("bend_impact", want.bend_impact, o_out_data.bend_impact);
                    check_field("bend_slope_var", want.bend_slope_var,
                                o_out_data.bend_slope_var);
                    check_field("bend_cross_cov", want.bend_cross_cov,
                                o_out_data.bend_cross_cov);
                    check_field("nonbend_slope", want.nonbend_slope,
                                o_out_data.nonbend_slope);
                    check_field("nonbend_impact", want.nonbend_impact,
                                o_out_data.nonbend_impact);
                    check_field("nonbend_slope_var", want.nonbend_slope_var,
                                o_out_data.nonbend_slope_var);
                    check_field("nonbend_cross_cov", want.nonbend_cross_cov,
                                o_out_data.nonbend_cross_cov);
                    check_field("zero_gap", want.zero_gap, o_out_data.zero_gap);
                end
            end
        end
    end

    // The watchdog ends a run in which no transaction moves on either side
    // for too long.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        err_count  = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_gap();
        test_field_extremes();
        test_saturation();
        test_rounding_ties();
        test_random_pairs();

        // Drain the pipeline, then allow for any stray late result.
        while (fits_pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && fits_pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
